/* sv/tksi_pkg.sv */
// tksi_pkg: shared types, constants and functions for the top-k sorted insert table
// depends on nothing; imported by the interfaces and every module of the block
package tksi_pkg;

  localparam int TAG_CHARS = 3;
  localparam int TAG_W     = 8 * TAG_CHARS;
  localparam int SCORE_W   = 30;
  localparam int BOARD_W   = 2;
  localparam int ROW_W     = 4;
  localparam int POS_W     = 4;
  localparam int ENT_W     = TAG_W + SCORE_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam int BUILTIN_BOARDS = 3;
  localparam int BUILTIN_ROWS   = 10;

  localparam logic [TAG_W-1:0] RECENT_RESET = "AAA";

  localparam logic [TAG_W-1:0] BUILTIN_TAGS [BUILTIN_BOARDS][BUILTIN_ROWS] = '{
    '{"DLC", "CRH", "PUP", "DHH", "RRH", "CAM", "ACE", "SKY", "OWL", "PIP"},
    '{"DLC", "CRH", "VON", "RRH", "SOP", "DHH", "RED", "CAM", "ACE", "PUP"},
    '{"DHH", "CRH", "VON", "DLC", "RED", "RRH", "ACE", "SOP", "CAM", "TRI"}
  };

  localparam logic [SCORE_W-1:0] BUILTIN_SCORES [BUILTIN_BOARDS][BUILTIN_ROWS] = '{
    '{30'd15225, 30'd13050, 30'd11300, 30'd10875, 30'd8700,
      30'd7150,  30'd6525,  30'd4350,  30'd2900,  30'd1225},
    '{30'd12400, 30'd10875, 30'd9650,  30'd8700,  30'd7125,
      30'd6525,  30'd5050,  30'd4350,  30'd2975,  30'd1650},
    '{30'd64850, 30'd52300, 30'd43775, 30'd38200, 30'd31450,
      30'd26900, 30'd21325, 30'd16750, 30'd11200, 30'd7650}
  };

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_issue;
    logic scan_step;
    logic rd_result;
    logic ins_result;
  } tksi_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic ranked;
    logic last_row;
    logic out_free;
  } tksi_status_t;

  function automatic logic [7:0] clean_char(input logic [7:0] c);
    logic [7:0] res;
    if (c >= 8'h61 && c <= 8'h7a) begin
      res = c - 8'h20;
    end else if ((c >= 8'h41 && c <= 8'h5a) || c == 8'h20) begin
      res = c;
    end else begin
      res = 8'h20;
    end
    return res;
  endfunction

  function automatic logic [TAG_W-1:0] clean_tag(input logic [TAG_W-1:0] raw);
    logic [TAG_W-1:0] t;
    for (int i = 0; i < TAG_CHARS; i++) begin
      t[i*8 +: 8] = clean_char(raw[i*8 +: 8]);
    end
    return t;
  endfunction

  // boards and rows past the built-in table repeat its last board and row
  function automatic logic [ENT_W-1:0] default_entry(input int unsigned b,
                                                     input int unsigned r);
    int unsigned sb;
    int unsigned sr;
    sb = (b < BUILTIN_BOARDS) ? b : BUILTIN_BOARDS - 1;
    sr = (r < BUILTIN_ROWS) ? r : BUILTIN_ROWS - 1;
    return {BUILTIN_TAGS[sb][sr], BUILTIN_SCORES[sb][sr]};
  endfunction

endpackage

/* sv/tksi_in_if.sv */
// tksi_in_if: request channel into the table (insert or row read)
// depends on tksi_pkg for field widths
interface tksi_in_if;
  import tksi_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [BOARD_W-1:0] board;
  logic [ROW_W-1:0]   row;
  logic [TAG_W-1:0]   tag_chars;
  logic [SCORE_W-1:0] score;

  modport source (output valid, cmd, board, row, tag_chars, score, input ready);
  modport sink   (input valid, cmd, board, row, tag_chars, score, output ready);
endinterface

/* sv/tksi_out_if.sv */
// tksi_out_if: result channel out of the table, one result per request
// depends on tksi_pkg for field widths
interface tksi_out_if;
  import tksi_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [POS_W-1:0]   position;
  logic [TAG_W-1:0]   row_tag;
  logic [SCORE_W-1:0] row_score;
  logic [TAG_W-1:0]   recent_tag;

  modport source (output valid, accepted, position, row_tag, row_score, recent_tag,
                  input ready);
  modport sink   (input valid, accepted, position, row_tag, row_score, recent_tag,
                  output ready);
endinterface

/* sv/tksi_ctrl.sv */
// tksi_ctrl: sequencer for clearing, row scan and result hand-off
// depends on tksi_pkg for the command and status structs
module tksi_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tksi_pkg::tksi_status_t st,
  output tksi_pkg::tksi_cmd_t    cmd
);
  import tksi_pkg::*;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DECODE   = 3'd2;
  localparam logic [2:0] S_RD_DONE  = 3'd3;
  localparam logic [2:0] S_INS_ADDR = 3'd4;
  localparam logic [2:0] S_INS_CMP  = 3'd5;
  localparam logic [2:0] S_INS_DONE = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st.is_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RD_DONE;
        end else if (st.ranked) begin
          state_nxt = S_INS_ADDR;
        end else begin
          state_nxt = S_INS_DONE;
        end
      end
      S_RD_DONE: begin
        if (st.out_free) begin
          cmd.rd_result = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INS_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd.scan_step = 1'b1;
        state_nxt     = st.last_row ? S_INS_DONE : S_INS_ADDR;
      end
      S_INS_DONE: begin
        if (st.out_free) begin
          cmd.ins_result = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/tksi_datapath.sv */
// tksi_datapath: request registers, board memory, scan carry and result register
// depends on tksi_pkg for widths, default table and tag cleaning
module tksi_datapath #(
  parameter int ROWS   = 10,
  parameter int BOARDS = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tksi_pkg::tksi_cmd_t         cmd,
  output tksi_pkg::tksi_status_t      st,
  input  logic                        in_cmd,
  input  logic [tksi_pkg::BOARD_W-1:0] in_board,
  input  logic [tksi_pkg::ROW_W-1:0]   in_row,
  input  logic [tksi_pkg::TAG_W-1:0]   in_tag_chars,
  input  logic [tksi_pkg::SCORE_W-1:0] in_score,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic [tksi_pkg::POS_W-1:0]   out_position,
  output logic [tksi_pkg::TAG_W-1:0]   out_row_tag,
  output logic [tksi_pkg::SCORE_W-1:0] out_row_score,
  output logic [tksi_pkg::TAG_W-1:0]   out_recent_tag
);
  import tksi_pkg::*;

  localparam int BW    = (BOARDS > 1) ? $clog2(BOARDS) : 1;
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = BW + RW;
  localparam int DEPTH = 1 << AW;

  logic               cmd_r;
  logic [BOARD_W-1:0] board_r;
  logic [ROW_W-1:0]   row_r;
  logic [TAG_W-1:0]   tag_r;
  logic [SCORE_W-1:0] score_r;

  logic [AW-1:0]      clr_r;
  logic [RW-1:0]      scan_r;
  logic               placed_r;
  logic [RW-1:0]      pos_r;
  logic [ENT_W-1:0]   carry_r;
  logic [TAG_W-1:0]   recent_r;

  logic [ENT_W-1:0]   mem [DEPTH];
  logic [ENT_W-1:0]   rdata_r;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_accepted_r;
  logic [POS_W-1:0]   out_position_r;
  logic [TAG_W-1:0]   out_row_tag_r;
  logic [SCORE_W-1:0] out_row_score_r;
  logic [TAG_W-1:0]   out_recent_tag_r;

  logic [BW-1:0]      bsel;
  logic               ranked;
  logic               row_ok;
  logic               beat;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENT_W-1:0]   wdata;
  logic [AW-1:0]      raddr;

  assign bsel   = BW'(board_r);
  assign ranked = 32'(board_r) < BOARDS;
  assign row_ok = 32'(row_r) < ROWS;
  assign beat   = score_r > rdata_r[SCORE_W-1:0];

  assign st.clr_last = clr_r == {AW{1'b1}};
  assign st.is_read  = cmd_r == CMD_READ;
  assign st.ranked   = ranked;
  assign st.last_row = scan_r == RW'(ROWS - 1);
  assign st.out_free = !out_valid_r || out_ready;

  assign raddr = (cmd_r == CMD_READ) ? {bsel, RW'(row_r)} : {bsel, scan_r};

  always_comb begin
    we    = 1'b0;
    waddr = {bsel, scan_r};
    wdata = carry_r;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = default_entry(int'(clr_r[AW-1 -: BW]), int'(clr_r[RW-1:0]));
    end else if (cmd.scan_step) begin
      priority if (placed_r) begin
        we = 1'b1;
      end else if (beat) begin
        we    = 1'b1;
        wdata = {tag_r, score_r};
      end else begin
        we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      board_r <= in_board;
      row_r   <= in_row;
      tag_r   <= clean_tag(in_tag_chars);
      score_r <= in_score;
    end
    if (cmd.scan_step && (placed_r || beat)) begin
      carry_r <= rdata_r;
    end
    if (cmd.scan_step && !placed_r && beat) begin
      pos_r <= scan_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      scan_r   <= '0;
      placed_r <= 1'b0;
      recent_r <= RECENT_RESET;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.load) begin
        scan_r   <= '0;
        placed_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_r <= scan_r + 1'b1;
        if (beat) begin
          placed_r <= 1'b1;
        end
      end
      if (cmd.ins_result && placed_r) begin
        recent_r <= tag_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.rd_result || cmd.ins_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_result) begin
      out_accepted_r   <= 1'b0;
      out_position_r   <= '0;
      out_row_tag_r    <= (ranked && row_ok) ? rdata_r[ENT_W-1 -: TAG_W] : '0;
      out_row_score_r  <= (ranked && row_ok) ? rdata_r[SCORE_W-1:0] : '0;
      out_recent_tag_r <= recent_r;
    end else if (cmd.ins_result) begin
      out_accepted_r   <= placed_r;
      out_position_r   <= placed_r ? POS_W'(pos_r) : '0;
      out_row_tag_r    <= '0;
      out_row_score_r  <= '0;
      out_recent_tag_r <= placed_r ? tag_r : recent_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_position   = out_position_r;
  assign out_row_tag    = out_row_tag_r;
  assign out_row_score  = out_row_score_r;
  assign out_recent_tag = out_recent_tag_r;

endmodule

/* sv/top_k_sorted_insert_table.sv */
// top_k_sorted_insert_table: top level joining the sequencer and the datapath
// depends on tksi_pkg, tksi_in_if, tksi_out_if, tksi_ctrl and tksi_datapath
//
// Keeps BOARDS high-score boards of ROWS rows each, sorted by descending score.
// in_if carries requests: cmd insert places a tag and score on a board, cmd
// read returns one stored row. out_if returns exactly one result per request,
// in request order.
// An insert walks the rows of its board through the single-port board memory,
// one row per read and compare pair, shifting rows down behind the new entry;
// an insert on an unranked board skips the walk. No new request is taken until
// the result of the last one has gone into the output register.
// After reset the block writes the built-in table into the board memory, one
// entry a cycle over 2**(clog2(BOARDS)+clog2(ROWS)) entries (64 by default),
// with in_if.ready low; then it takes requests.
// A finished result sits in the output register until out_if.ready; the next
// request is taken meanwhile, and its own result waits for the register.
module top_k_sorted_insert_table #(
  parameter int ROWS   = 10,
  parameter int BOARDS = 3
) (
  input logic       clk,
  input logic       rst_n,
  tksi_in_if.sink   in_if,
  tksi_out_if.source out_if
);
  import tksi_pkg::*;

  tksi_cmd_t    cmd;
  tksi_status_t st;

  tksi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tksi_datapath #(
    .ROWS   (ROWS),
    .BOARDS (BOARDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_cmd         (in_if.cmd),
    .in_board       (in_if.board),
    .in_row         (in_if.row),
    .in_tag_chars   (in_if.tag_chars),
    .in_score       (in_if.score),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_accepted   (out_if.accepted),
    .out_position   (out_if.position),
    .out_row_tag    (out_if.row_tag),
    .out_row_score  (out_if.row_score),
    .out_recent_tag (out_if.recent_tag)
  );

endmodule

/* sv/tksi_checker.sv */
// tksi_checker: port-level assertions for the top-k sorted insert table
// depends on tksi_pkg; bound to top_k_sorted_insert_table below
module tksi_checker #(
  parameter int ROWS = 10
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_accepted,
  input logic [tksi_pkg::POS_W-1:0]   out_position,
  input logic [tksi_pkg::TAG_W-1:0]   out_row_tag,
  input logic [tksi_pkg::SCORE_W-1:0] out_row_score,
  input logic [tksi_pkg::TAG_W-1:0]   out_recent_tag
);
  import tksi_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted)
      && $stable(out_position) && $stable(out_row_tag)
      && $stable(out_row_score) && $stable(out_recent_tag))
    else $error("stalled result changed");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during clearing pass");

  a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_position == '0)
    else $error("rejected result with non-zero position");

  a_accept_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> 32'(out_position) < ROWS
      && out_row_tag == '0 && out_row_score == '0)
    else $error("placed insert with bad position or row fields");

endmodule

bind top_k_sorted_insert_table tksi_checker #(.ROWS(ROWS)) u_tksi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_accepted   (out_if.accepted),
  .out_position   (out_if.position),
  .out_row_tag    (out_if.row_tag),
  .out_row_score  (out_if.row_score),
  .out_recent_tag (out_if.recent_tag)
);
